/* rtl/core/bb33_pkg.sv */
`default_nettype none

package bb33_pkg;

  // Sizes
  localparam int unsigned MaxWidthDefault = 2048;
  localparam int unsigned WidthRegW       = 12;
  localparam int unsigned HeightRegW      = 16;
  localparam int unsigned InRowW          = HeightRegW + 1;
  localparam int unsigned ChanW           = 8;
  localparam int unsigned NumChan         = 3;
  localparam int unsigned PixelW          = NumChan * ChanW;
  localparam int unsigned SumW            = 12;
  localparam int unsigned CntW            = 4;
  localparam int unsigned NumW            = SumW + 1;
  localparam int unsigned DvsW            = CntW + 1;
  localparam int unsigned CfgIndexW       = 8;
  localparam int unsigned CfgDataW        = 16;
  localparam int unsigned NumRows         = 3;
  localparam int unsigned SlotW           = 2;
  localparam int unsigned TapIdxW         = 3;
  localparam int unsigned NumStoredTaps   = 8;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CfgImageWidth  = CfgIndexW'(0),
    CfgImageHeight = CfgIndexW'(1)
  } cfg_reg_e;

  // Offset of a window tap from the center pixel
  typedef enum logic [1:0] {
    OffMinus,
    OffZero,
    OffPlus
  } tap_off_e;

  // Row offset of stored tap k (k / 3 - 1)
  function automatic tap_off_e tap_row_off(input logic [TapIdxW-1:0] k);
    tap_off_e off;
    case (k) inside
      [3'd0:3'd2]: off = OffMinus;
      [3'd3:3'd5]: off = OffZero;
      default:     off = OffPlus;
    endcase
    return off;
  endfunction

  // Column offset of stored tap k (k % 3 - 1)
  function automatic tap_off_e tap_col_off(input logic [TapIdxW-1:0] k);
    tap_off_e off;
    case (k) inside
      3'd0, 3'd3, 3'd6: off = OffMinus;
      3'd1, 3'd4, 3'd7: off = OffZero;
      default:          off = OffPlus;
    endcase
    return off;
  endfunction

  // Row slot of the next row, modulo the row count
  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    return (s == SlotW'(NumRows - 1)) ? '0 : s + SlotW'(1);
  endfunction

  // Row slot of the previous row, modulo the row count
  function automatic logic [SlotW-1:0] slot_prev(input logic [SlotW-1:0] s);
    return (s == '0) ? SlotW'(NumRows - 1) : s - SlotW'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bb33_row_mem.sv */
`default_nettype none

// Row store: three image rows, one read and one write port, registered read
module bb33_row_mem #(
  parameter int unsigned MaxWidth = bb33_pkg::MaxWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rd_en_i,
  input  wire logic [bb33_pkg::SlotW-1:0]     rd_slot_i,
  input  wire logic [ColW-1:0]                rd_col_i,
  output logic      [bb33_pkg::PixelW-1:0]    rd_data_o,
  input  wire logic                           wr_en_i,
  input  wire logic [bb33_pkg::SlotW-1:0]     wr_slot_i,
  input  wire logic [ColW-1:0]                wr_col_i,
  input  wire logic [bb33_pkg::PixelW-1:0]    wr_data_i
);

  localparam int unsigned ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned Depth = bb33_pkg::NumRows * MaxWidth;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [bb33_pkg::PixelW-1:0] mem_q [Depth];
  logic [bb33_pkg::PixelW-1:0] rd_q;
  logic [AddrW-1:0]            rd_addr;
  logic [AddrW-1:0]            wr_addr;

  // Map a row slot and column to a flat address
  function automatic logic [AddrW-1:0] to_addr(input logic [bb33_pkg::SlotW-1:0] slot,
                                               input logic [ColW-1:0] col);
    logic [AddrW-1:0] base;
    case (slot)
      bb33_pkg::SlotW'(0): base = '0;
      bb33_pkg::SlotW'(1): base = AddrW'(MaxWidth);
      default:             base = AddrW'(2 * MaxWidth);
    endcase
    return base + AddrW'(col);
  endfunction

  assign rd_addr = to_addr(rd_slot_i, rd_col_i);
  assign wr_addr = to_addr(wr_slot_i, wr_col_i);

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
  end

  // Read one entry into a register; data follows in the next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* rtl/core/bb33_divider.sv */
`default_nettype none

// Three-channel restoring divider, one quotient bit per cycle
module bb33_divider (
  input  wire logic                                                 clk_i,
  input  wire logic                                                 rst_ni,
  input  wire logic                                                 start_i,
  input  wire logic [bb33_pkg::NumChan-1:0][bb33_pkg::NumW-1:0]     num_i,
  input  wire logic [bb33_pkg::DvsW-1:0]                            dvs_i,
  output logic                                                      done_o,
  output logic      [bb33_pkg::NumChan-1:0][bb33_pkg::ChanW-1:0]    quo_o
);

  localparam int unsigned StepW = $clog2(bb33_pkg::ChanW);

  logic [bb33_pkg::NumChan-1:0][bb33_pkg::NumW-1:0]  rem_q, rem_d;
  logic [bb33_pkg::NumChan-1:0][bb33_pkg::ChanW-1:0] quo_q, quo_d;
  logic [bb33_pkg::NumW-1:0]                         dvs_q, dvs_d;
  logic [StepW-1:0]                                  step_q, step_d;
  logic                                              busy_q, busy_d;
  logic                                              done_q, done_d;

  // Load on start, then subtract the shifted divisor where it fits
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dvs_d  = bb33_pkg::NumW'(dvs_i) << (bb33_pkg::ChanW - 1);
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int ch = 0; ch < bb33_pkg::NumChan; ch++) begin
        if (rem_q[ch] >= dvs_q) begin
          rem_d[ch] = rem_q[ch] - dvs_q;
          quo_d[ch] = {quo_q[ch][bb33_pkg::ChanW-2:0], 1'b1};
        end else begin
          quo_d[ch] = {quo_q[ch][bb33_pkg::ChanW-2:0], 1'b0};
        end
      end
      dvs_d  = dvs_q >> 1;
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(bb33_pkg::ChanW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/core/box_blur_3x3_edge_average_core.sv */
`default_nettype none

// 3x3 box blur on an RGB raster stream. Each output channel is the average of the in-image
// neighbors of a pixel (itself included), rounded half up. The result for a pixel leaves
// width+1 items after that pixel came in, so after the last pixel of an image send width+1
// drain requests (tuser high); a drain before the last pixel is dropped, a pixel after it
// counts as a drain. tlast marks the image's final result, after which a new image starts.
// Writing either configuration register also starts a new image. Items are handled one at
// a time: an item that produces no result only updates the row store and the positions;
// an item that produces one takes longer, set by the up to eight neighbor reads through the
// single read port of the row store and the quotient loop of the divider, plus any wait on
// the output. The row store needs no clearing pass; only entries already written are ever read.
module box_blur_3x3_edge_average_core #(
  parameter int unsigned MaxWidth = bb33_pkg::MaxWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bb33_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire logic [bb33_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel input
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [bb33_pkg::PixelW-1:0]       s_axis_tdata_i,  // pixel_blue, pixel_green, pixel_red
  input  wire logic                              s_axis_tuser_i,  // command
  // result output
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [bb33_pkg::PixelW-1:0]       m_axis_tdata_o,  // out_blue, out_green, out_red
  output logic                                   m_axis_tlast_o   // end_of_image
);

  localparam int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CmpW = ((ColW > bb33_pkg::WidthRegW) ? ColW : bb33_pkg::WidthRegW) + 1;
  localparam int unsigned RowW = bb33_pkg::HeightRegW;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StTail,
    StDivLoad,
    StDivWait,
    StEmit,
    StCommit
  } state_e;

  state_e                                            state_q, state_d;
  logic [bb33_pkg::WidthRegW-1:0]                    width_q, width_d;
  logic [bb33_pkg::HeightRegW-1:0]                   height_q, height_d;
  logic [bb33_pkg::InRowW-1:0]                       in_row_q, in_row_d;
  logic [ColW-1:0]                                   in_col_q, in_col_d;
  logic [bb33_pkg::SlotW-1:0]                        in_slot_q, in_slot_d;
  logic [RowW-1:0]                                   out_row_q, out_row_d;
  logic [ColW-1:0]                                   out_col_q, out_col_d;
  logic [bb33_pkg::SlotW-1:0]                        out_slot_q, out_slot_d;
  logic [bb33_pkg::PixelW-1:0]                       pix_q, pix_d;
  logic                                              have_pix_q, have_pix_d;
  logic                                              emit_q, emit_d;
  logic                                              last_q, last_d;
  logic [bb33_pkg::TapIdxW-1:0]                      tap_q, tap_d;
  logic                                              pend_q, pend_d;
  logic [bb33_pkg::NumChan-1:0][bb33_pkg::SumW-1:0]  sum_q, sum_d;
  logic [bb33_pkg::CntW-1:0]                         cnt_q, cnt_d;
  logic                                              m_valid_q, m_valid_d;
  logic [bb33_pkg::PixelW-1:0]                       m_data_q, m_data_d;
  logic                                              m_last_q, m_last_d;

  logic [bb33_pkg::WidthRegW-1:0]                    w_eff;
  logic [bb33_pkg::HeightRegW-1:0]                   h_eff;
  logic                                              cfg_accept;
  logic                                              s_accept;
  logic                                              in_image;
  logic                                              emit_now;
  logic                                              in_col_wrap;
  logic                                              out_col_wrap;
  logic                                              row_next_ok;
  logic                                              col_next_ok;
  logic                                              eoi;
  bb33_pkg::tap_off_e                                row_off;
  bb33_pkg::tap_off_e                                col_off;
  logic                                              row_ok;
  logic                                              col_ok;
  logic                                              tap_ok;
  logic [bb33_pkg::SlotW-1:0]                        tap_slot;
  logic [ColW-1:0]                                   tap_col;
  logic                                              rd_en;
  logic [bb33_pkg::PixelW-1:0]                       rd_data;
  logic                                              wr_en;
  logic                                              restart;
  logic                                              div_start;
  logic                                              div_done;
  logic [bb33_pkg::NumChan-1:0][bb33_pkg::NumW-1:0]  div_num;
  logic [bb33_pkg::DvsW-1:0]                         div_dvs;
  logic [bb33_pkg::NumChan-1:0][bb33_pkg::ChanW-1:0] div_quo;

  // Effective image size: zero reads as one, width saturates at the store size
  always_comb begin
    if (width_q == '0) begin
      w_eff = bb33_pkg::WidthRegW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = bb33_pkg::WidthRegW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? bb33_pkg::HeightRegW'(1) : height_q;
  end

  // Handshakes: configuration wins over a pixel request in the same cycle
  assign cfg_ready_o     = (state_q == StIdle);
  assign s_axis_tready_o = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_accept      = cfg_valid_i && cfg_ready_o;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Position decode
  assign in_image     = in_row_q < bb33_pkg::InRowW'(h_eff);
  assign emit_now     = (in_row_q >= bb33_pkg::InRowW'(2)) ||
                        ((in_row_q == bb33_pkg::InRowW'(1)) && (in_col_q != '0));
  assign in_col_wrap  = (CmpW'(in_col_q) + CmpW'(1)) >= CmpW'(w_eff);
  assign out_col_wrap = (CmpW'(out_col_q) + CmpW'(1)) >= CmpW'(w_eff);
  assign row_next_ok  = (bb33_pkg::InRowW'(out_row_q) + bb33_pkg::InRowW'(1)) <
                        bb33_pkg::InRowW'(h_eff);
  assign col_next_ok  = !out_col_wrap;
  assign eoi          = (out_row_q == (h_eff - bb33_pkg::HeightRegW'(1))) && out_col_wrap;

  // Neighbor tap of the current read step
  assign row_off = bb33_pkg::tap_row_off(tap_q);
  assign col_off = bb33_pkg::tap_col_off(tap_q);

  always_comb begin
    case (row_off)
      bb33_pkg::OffMinus: begin
        row_ok   = (out_row_q != '0);
        tap_slot = bb33_pkg::slot_prev(out_slot_q);
      end
      bb33_pkg::OffZero: begin
        row_ok   = 1'b1;
        tap_slot = out_slot_q;
      end
      default: begin
        row_ok   = row_next_ok;
        tap_slot = bb33_pkg::slot_next(out_slot_q);
      end
    endcase
    case (col_off)
      bb33_pkg::OffMinus: begin
        col_ok  = (out_col_q != '0);
        tap_col = out_col_q - ColW'(1);
      end
      bb33_pkg::OffZero: begin
        col_ok  = 1'b1;
        tap_col = out_col_q;
      end
      default: begin
        col_ok  = col_next_ok;
        tap_col = out_col_q + ColW'(1);
      end
    endcase
  end

  assign tap_ok = row_ok && col_ok;
  assign rd_en  = (state_q == StRead) && tap_ok;
  assign wr_en  = (state_q == StCommit) && have_pix_q;

  // Row store
  bb33_row_mem #(
    .MaxWidth (MaxWidth)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_slot_i (tap_slot),
    .rd_col_i  (tap_col),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_slot_i (in_slot_q),
    .wr_col_i  (in_col_q),
    .wr_data_i (pix_q)
  );

  // Rounded average: (2*sum + count) / (2*count)
  always_comb begin
    for (int ch = 0; ch < bb33_pkg::NumChan; ch++) begin
      div_num[ch] = bb33_pkg::NumW'({sum_q[ch], 1'b0}) + bb33_pkg::NumW'(cnt_q);
    end
  end

  assign div_dvs   = {cnt_q, 1'b0};
  assign div_start = (state_q == StDivLoad);

  bb33_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    width_d    = width_q;
    height_d   = height_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    pix_d      = pix_q;
    have_pix_d = have_pix_q;
    emit_d     = emit_q;
    last_d     = last_q;
    tap_d      = tap_q;
    pend_d     = 1'b0;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    restart    = 1'b0;

    case (state_q)
      StIdle: begin
        if (cfg_accept) begin
          case (bb33_pkg::cfg_reg_e'(cfg_index_i))
            bb33_pkg::CfgImageWidth: begin
              width_d = cfg_data_i[bb33_pkg::WidthRegW-1:0];
              restart = 1'b1;
            end
            bb33_pkg::CfgImageHeight: begin
              height_d = cfg_data_i[bb33_pkg::HeightRegW-1:0];
              restart  = 1'b1;
            end
            default: ;
          endcase
        end else if (s_accept && !(s_axis_tuser_i && in_image)) begin
          // Take the request; a pixel past the image end counts as a drain
          pix_d      = s_axis_tdata_i;
          have_pix_d = !s_axis_tuser_i && in_image;
          emit_d     = emit_now;
          tap_d      = '0;
          sum_d      = '0;
          cnt_d      = '0;
          state_d    = emit_now ? StRead : StCommit;
        end
      end

      StRead: begin
        // Issue one neighbor read, add the one that came back
        for (int ch = 0; ch < bb33_pkg::NumChan; ch++) begin
          if (pend_q) begin
            sum_d[ch] = sum_q[ch] + bb33_pkg::SumW'(rd_data[ch*bb33_pkg::ChanW +: bb33_pkg::ChanW]);
          end
        end
        if (tap_ok) begin
          cnt_d = cnt_q + bb33_pkg::CntW'(1);
        end
        pend_d = tap_ok;
        tap_d  = tap_q + bb33_pkg::TapIdxW'(1);
        if (tap_q == bb33_pkg::TapIdxW'(bb33_pkg::NumStoredTaps - 1)) begin
          state_d = StTail;
        end
      end

      StTail: begin
        // Add the last read and the incoming pixel at the lower right
        for (int ch = 0; ch < bb33_pkg::NumChan; ch++) begin
          sum_d[ch] = sum_q[ch]
                    + (pend_q ? bb33_pkg::SumW'(rd_data[ch*bb33_pkg::ChanW +: bb33_pkg::ChanW])
                              : '0)
                    + ((row_next_ok && col_next_ok && have_pix_q)
                       ? bb33_pkg::SumW'(pix_q[ch*bb33_pkg::ChanW +: bb33_pkg::ChanW]) : '0);
        end
        if (row_next_ok && col_next_ok) begin
          cnt_d = cnt_q + bb33_pkg::CntW'(1);
        end
        state_d = StDivLoad;
      end

      StDivLoad: begin
        state_d = StDivWait;
      end

      StDivWait: begin
        if (div_done) begin
          state_d = StEmit;
        end
      end

      StEmit: begin
        // Load the output register once it is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = div_quo;
          m_last_d  = eoi;
          last_d    = eoi;
          state_d   = StCommit;
        end
      end

      StCommit: begin
        // Advance positions; the row store write happens this cycle
        if (in_col_wrap) begin
          in_col_d  = '0;
          in_row_d  = in_row_q + bb33_pkg::InRowW'(1);
          in_slot_d = bb33_pkg::slot_next(in_slot_q);
        end else begin
          in_col_d  = in_col_q + ColW'(1);
        end
        if (emit_q) begin
          if (last_q) begin
            restart = 1'b1;
          end else if (out_col_wrap) begin
            out_col_d  = '0;
            out_row_d  = out_row_q + RowW'(1);
            out_slot_d = bb33_pkg::slot_next(out_slot_q);
          end else begin
            out_col_d  = out_col_q + ColW'(1);
          end
        end
        state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // New image: all positions back to the start
    if (restart) begin
      in_row_d   = '0;
      in_col_d   = '0;
      in_slot_d  = '0;
      out_row_d  = '0;
      out_col_d  = '0;
      out_slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      width_q    <= bb33_pkg::WidthRegW'(1);
      height_q   <= bb33_pkg::HeightRegW'(1);
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      pix_q      <= '0;
      have_pix_q <= 1'b0;
      emit_q     <= 1'b0;
      last_q     <= 1'b0;
      tap_q      <= '0;
      pend_q     <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      height_q   <= height_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      pix_q      <= pix_d;
      have_pix_q <= have_pix_d;
      emit_q     <= emit_d;
      last_q     <= last_d;
      tap_q      <= tap_d;
      pend_q     <= pend_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      m_last_q   <= m_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

/* rtl/core/bb33_checker.sv */
`default_nettype none

module bb33_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [bb33_pkg::CfgIndexW-1:0] cfg_index_i,
  input wire logic [bb33_pkg::CfgDataW-1:0]  cfg_data_i,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [bb33_pkg::PixelW-1:0]    s_axis_tdata_i,
  input wire logic                           s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [bb33_pkg::PixelW-1:0]    m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o
);

  // Never take a configuration write and a pixel request in the same cycle
  a_no_dual_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid_i && s_axis_tready_o && cfg_valid_i && cfg_ready_o))
    else $error("configuration and pixel request accepted together");

  // A pixel request always takes the block out of idle, so ready drops once it is taken
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("ready again right after a pixel request");

  // A new result appears only out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> (!$past(s_axis_tready_o) && !$past(cfg_ready_o)))
    else $error("result appeared while the block was idle");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind box_blur_3x3_edge_average_core bb33_checker u_bb33_checker (.*);

`default_nettype wire

/* bench/box_blur_checker.sv */
`default_nettype none

// Watches the configuration, pixel and result channels of the blur core, predicts every blurred
// pixel from the accepted requests and compares each accepted result with the oldest prediction.
module box_blur_checker
  import bb33_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 s_axis_tvalid_i,
  input  wire logic                 s_axis_tready_i,
  input  wire logic [PixelW-1:0]    s_axis_tdata_i,  // pixel_blue, pixel_green, pixel_red
  input  wire logic                 s_axis_tuser_i,  // command
  input  wire logic                 m_axis_tvalid_i,
  input  wire logic                 m_axis_tready_i,
  input  wire logic [PixelW-1:0]    m_axis_tdata_i,  // out_blue, out_green, out_red
  input  wire logic                 m_axis_tlast_i,  // end_of_image
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             last;
  } blurred_pixel_t;

  // Predicted image state
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  logic [InRowW-1:0]     in_row;
  logic [WidthRegW-1:0]  in_col;
  logic [HeightRegW-1:0] out_row;
  logic [WidthRegW-1:0]  out_col;
  logic [PixelW-1:0]     row_mem [NumRows][MaxWidth];

  blurred_pixel_t blurred_q[$];
  int             fail_count;

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  function automatic logic [ChanW-1:0] round_mean(int unsigned sum, int unsigned taps);
    return ChanW'((2 * sum + taps) / (2 * taps));
  endfunction

  task automatic restart_image();
    in_row  = '0;
    in_col  = '0;
    out_row = '0;
    out_col = '0;
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Advance the raster position by one request and queue the blurred pixel it releases
  task automatic predict_blur(input logic drain, input logic [PixelW-1:0] pix);
    int unsigned    w, h, pos, sum_b, sum_g, sum_r, taps;
    int             dr, dc, rr, cc;
    logic           have_pix;
    logic [PixelW-1:0] v;
    blurred_pixel_t res;
    w   = active_width();
    h   = active_height();
    pos = in_row * w + in_col;
    // drop drains that arrive while pixels are still due
    if (pos < w * h && drain) return;
    have_pix = (pos < w * h);
    if (pos >= w + 1) begin
      sum_b = 0;
      sum_g = 0;
      sum_r = 0;
      taps  = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          rr = int'(out_row) + dr;
          cc = int'(out_col) + dc;
          if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
          // the lower right neighbor is the pixel arriving now
          if (dr == 1 && dc == 1) v = have_pix ? pix : '0;
          else v = row_mem[rr % NumRows][cc];
          sum_b += v[ChanW-1:0];
          sum_g += v[2*ChanW-1:ChanW];
          sum_r += v[3*ChanW-1:2*ChanW];
          taps++;
        end
      end
      res.blue  = round_mean(sum_b, taps);
      res.green = round_mean(sum_g, taps);
      res.red   = round_mean(sum_r, taps);
      res.last  = (out_row == h - 1) && (out_col == w - 1);
      blurred_q.push_back(res);
    end
    if (have_pix) row_mem[in_row % NumRows][in_col] = pix;
    if (in_col + 1 >= w) begin
      in_col = '0;
      in_row++;
    end else begin
      in_col++;
    end
    if (pos >= w + 1) begin
      if (res.last) begin
        restart_image();
      end else if (out_col + 1 >= w) begin
        out_col = '0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blurred_pixel_t want;
    if (!rst_ni) begin
      width_reg  = WidthRegW'(1);
      height_reg = HeightRegW'(1);
      restart_image();
      blurred_q.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // check the result first, it always belongs to an earlier request
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (blurred_q.size() == 0) begin
          note_failure($sformatf("unexpected result b=%02x g=%02x r=%02x last=%0b",
                                 m_axis_tdata_i[7:0], m_axis_tdata_i[15:8],
                                 m_axis_tdata_i[23:16], m_axis_tlast_i));
        end else begin
          want = blurred_q.pop_front();
          if (want.blue != m_axis_tdata_i[ChanW-1:0] ||
              want.green != m_axis_tdata_i[2*ChanW-1:ChanW] ||
              want.red != m_axis_tdata_i[3*ChanW-1:2*ChanW] ||
              want.last != m_axis_tlast_i) begin
            note_failure($sformatf(
              "result mismatch: expected b=%02x g=%02x r=%02x last=%0b, got b=%02x g=%02x r=%02x last=%0b",
              want.blue, want.green, want.red, want.last,
              m_axis_tdata_i[7:0], m_axis_tdata_i[15:8], m_axis_tdata_i[23:16],
              m_axis_tlast_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgImageWidth: begin
            width_reg = cfg_data_i[WidthRegW-1:0];
            restart_image();
          end
          CfgImageHeight: begin
            height_reg = cfg_data_i[HeightRegW-1:0];
            restart_image();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_blur(s_axis_tuser_i, s_axis_tdata_i);
      fail_count_o <= fail_count;
      pending_o    <= blurred_q.size();
    end
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb
  import bb33_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWidth       = MaxWidthDefault;
  localparam int unsigned ItemTarget     = 700;
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned PressureAfter  = 100;
  localparam int unsigned PressureCycles = 500;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam logic [CfgIndexW-1:0] CfgUnusedIndex = '1;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i      = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [PixelW-1:0]    s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [PixelW-1:0]    m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  int          fail_count;
  int          pending;
  int unsigned idle_cycles = 0;
  int unsigned sent_items  = 0;
  bit          no_gaps     = 1'b0;

  always #5 clk_i = ~clk_i;

  box_blur_3x3_edge_average_core #(
    .MaxWidth(MaxWidth)
  ) u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  box_blur_checker #(
    .MaxWidth(MaxWidth)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Abort when no channel moves a request for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [PixelW-1:0] random_pixel();
    logic [PixelW-1:0] pix;
    int unsigned       r;
    pix = PixelW'($urandom());
    for (int ch = 0; ch < NumChan; ch++) begin
      r = $urandom_range(0, 9);
      if (r == 0) pix[ch*ChanW +: ChanW] = '0;
      else if (r == 1) pix[ch*ChanW +: ChanW] = '1;
    end
    return pix;
  endfunction

  function automatic int unsigned width_of(input logic [CfgDataW-1:0] data);
    if (data[WidthRegW-1:0] == '0) return 1;
    if (data[WidthRegW-1:0] > MaxWidth) return MaxWidth;
    return data[WidthRegW-1:0];
  endfunction

  function automatic int unsigned height_of(input logic [CfgDataW-1:0] data);
    return (data == '0) ? 1 : data;
  endfunction

  // Receiver: random runs and stalls, plus one long hold once results flow
  initial begin : receiver
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned taken;
    bit          held;
    run_left   = 0;
    stall_left = 0;
    taken      = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) taken++;
      if (!held && taken >= PressureAfter && s_axis_tvalid_i) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (PressureCycles) @(posedge clk_i);
      end else if (run_left != 0) begin
        m_axis_tready_i <= 1'b1;
        run_left--;
      end else if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        stall_left = pick_gap();
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic offer_request(input logic drain, input logic [PixelW-1:0] pix);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= drain;
    s_axis_tdata_i  <= drain ? PixelW'($urandom()) : pix;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure_image(input logic [CfgDataW-1:0] width_data,
                                 input logic [CfgDataW-1:0] height_data);
    if ($urandom_range(0, 1) == 0) begin
      write_register(CfgImageWidth, width_data);
      write_register(CfgImageHeight, height_data);
    end else begin
      write_register(CfgImageHeight, height_data);
      write_register(CfgImageWidth, width_data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, drain all predicted results, then let the core go quiet
  task automatic finish_phase();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One image in raster order with stray drains; a full image ends with width+1 flush requests
  task automatic send_image(input int unsigned w, input int unsigned h, input bit full);
    int unsigned npix;
    npix = full ? w * h : $urandom_range(1, w * h);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 19) == 0) offer_request(1'b1, '0);
      offer_request(1'b0, random_pixel());
      sent_items++;
    end
    if (full) begin
      for (int unsigned t = 0; t <= w; t++) begin
        // a pixel past the end counts as a flush request
        offer_request($urandom_range(0, 4) != 0, random_pixel());
        sent_items++;
      end
      if ($urandom_range(0, 9) == 0) offer_request(1'b1, '0);
    end
  endtask

  initial begin : stimulus
    logic [CfgDataW-1:0] width_data;
    logic [CfgDataW-1:0] height_data;
    int unsigned         r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single pixel image at the reset size: stray drain, pixel, late pixel as flush, drain
    offer_request(1'b1, '0);
    offer_request(1'b0, 24'hFFFFFF);
    offer_request(1'b0, 24'h5A5A5A);
    offer_request(1'b1, '0);
    finish_phase();

    // 3x2 image of extremes; upper width bits are masked off
    configure_image(16'hF003, 16'h0002);
    offer_request(1'b1, '0);
    offer_request(1'b0, 24'h000000);
    offer_request(1'b0, 24'hFFFFFF);
    offer_request(1'b0, 24'h000000);
    finish_phase();
    // a write to an unknown register must not restart the image
    write_register(CfgUnusedIndex, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    offer_request(1'b0, 24'hFFFFFF);
    offer_request(1'b0, 24'hFFFFFF);
    offer_request(1'b0, 24'h00FF80);
    repeat (4) offer_request(1'b1, '0);
    finish_phase();

    // Zero width and height act as one
    configure_image(16'h0000, 16'h0000);
    offer_request(1'b0, 24'h123456);
    offer_request(1'b1, '0);
    offer_request(1'b1, '0);
    finish_phase();

    // Tallest image, broken off after a few rows
    configure_image(16'h0002, 16'hFFFF);
    repeat (12) offer_request(1'b0, random_pixel());
    finish_phase();

    // Width beyond the line buffer saturates to the widest row
    configure_image(16'h0FFF, 16'h0001);
    send_image(MaxWidth, 1, 1'b1);
    finish_phase();

    // Random image sizes, mostly small
    sent_items = 0;
    while (sent_items < ItemTarget) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r < 14) width_data = CfgDataW'($urandom_range(1, 6));
      else if (r < 17) width_data = CfgDataW'($urandom_range(7, 24));
      else if (r == 17) width_data = '0;
      else width_data = {4'($urandom()), 12'($urandom_range(1, 4))};
      r = $urandom_range(0, 9);
      if (r < 7) height_data = CfgDataW'($urandom_range(1, 5));
      else if (r < 9) height_data = CfgDataW'($urandom_range(8, 12));
      else height_data = '0;
      configure_image(width_data, height_data);
      repeat ($urandom_range(1, 3)) begin
        send_image(width_of(width_data), height_of(height_data), 1'b1);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_image(width_of(width_data), height_of(height_data), 1'b0);
      end
      finish_phase();
    end
    no_gaps = 1'b0;

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/bb33_pkg.sv
rtl/core/bb33_row_mem.sv
rtl/core/bb33_divider.sv
rtl/core/box_blur_3x3_edge_average_core.sv
rtl/core/bb33_checker.sv
bench/box_blur_checker.sv
bench/tb.sv
